/* rtl/pkgrld_pkg.sv */
// shared types and constants for the pk glyph run length decoder
// no dependencies

package pkgrld_pkg;

    localparam int ROW_BITS = 64;
    localparam int COL_W    = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_DYN_F       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_BLACK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PKT_BYTES   = 3'd4;

    localparam logic [3:0] DYN_F_RAW  = 4'd14;
    localparam logic [3:0] DYN_F_MAX  = 4'd13;
    localparam logic [3:0] NYB_REPEAT = 4'd14;
    localparam logic [3:0] NYB_REP1   = 4'd15;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_REP_FIRST = 3'd1;
    localparam logic [2:0] PH_TWO       = 3'd2;
    localparam logic [2:0] PH_ZEROS     = 3'd4;
    localparam logic [2:0] PH_DIGITS    = 3'd6;

    localparam logic [9:0] SEEN_MAX = 10'd1023;

    typedef struct packed {
        logic load_in;
        logic start;
        logic inc_seen;
        logic clr_seen;
        logic emit_err;
        logic nyb_step;
        logic nyb_sel;
        logic run_step;
        logic run_end;
        logic emit_row;
        logic dec_rep;
        logic row_final;
        logic raw_begin;
        logic raw_step;
        logic fill;
        logic clr_num;
    } t_cmd;

    typedef struct packed {
        logic seen_zero;
        logic raw;
        logic short_pkt;
        logic finished;
        logic nyb_is_run;
        logic run_zero;
        logic col_ge_w;
        logic take_fills;
        logic raw_fills;
        logic rc_lt_h;
        logic rep_nz;
        logic bits_zero;
        logic last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/pk_glyph_run_length_decoder.sv */
// top level of the pk glyph run length decoder
// depends on pkgrld_pkg, pkgrld_ctrl, pkgrld_dp
//
// usage:
//   config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   dyn_f (0), first_run_black (1), width (2), height (3), packet_bytes (4);
//   write only while the decoder is idle. the port is always ready.
//   input channel takes one packet byte per item, high nybble first, with
//   i_last_byte on the last byte of the glyph packet.
//   output channel gives one bitmap row per item, 1 white, column x in bit 63-x,
//   or a single error item with o_short_packet for a too short raw packet.
// sequence:
//   one byte is taken at a time: it is loaded, checked and dispatched, then
//   its nybbles are decoded in packed mode or its bits in raw mode; each run
//   paints its row segments and then ends, each finished row is put out with
//   its repeated rows, and the error item for a short raw packet comes first;
//   the glyph end puts out the missing rows.
//   a row item is valid from the cycle after it is formed until it is taken.
// reset: synchronous active low, control and config registers to defaults,
//   no item pending; the held byte and the output item fields are not reset.
// stall: while the output item is not taken, row output and hence the input
//   side wait; no item is lost or repeated.

module pk_glyph_run_length_decoder #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pkgrld_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pkgrld_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_data_byte,
    input  logic                             i_last_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pkgrld_pkg::ROW_BITS-1:0]  o_row_bits,
    output logic [5:0]                       o_row_number,
    output logic                             o_glyph_done,
    output logic                             o_short_packet
);
    import pkgrld_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    pkgrld_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    pkgrld_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_row_bits     (o_row_bits),
        .o_row_number   (o_row_number),
        .o_glyph_done   (o_glyph_done),
        .o_short_packet (o_short_packet),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

/* rtl/pkgrld_ctrl.sv */
// sequencer for the pk glyph decoder: byte dispatch, run loop, row output loop
// depends on pkgrld_pkg

module pkgrld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pkgrld_pkg::t_stat i_stat,
    output pkgrld_pkg::t_cmd  o_cmd
);
    import pkgrld_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BEGIN = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_DISP  = 4'd3;
    localparam logic [3:0] S_NYB   = 4'd4;
    localparam logic [3:0] S_RUN   = 4'd5;
    localparam logic [3:0] S_FR1   = 4'd6;
    localparam logic [3:0] S_FRR   = 4'd7;
    localparam logic [3:0] S_RAW   = 4'd8;
    localparam logic [3:0] S_LAST  = 4'd9;
    localparam logic [3:0] S_FILL  = 4'd10;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;
    logic       r_sel, n_sel;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.nyb_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_BEGIN;
                end
            end
            S_BEGIN: begin
                o_cmd.start    = i_stat.seen_zero;
                o_cmd.inc_seen = 1'b1;
                if (i_stat.seen_zero && i_stat.raw && i_stat.short_pkt) n_state = S_ERR;
                else n_state = S_DISP;
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.finished) begin
                    n_state = S_LAST;
                end else if (i_stat.raw) begin
                    o_cmd.raw_begin = 1'b1;
                    n_state = S_RAW;
                end else begin
                    n_sel   = 1'b0;
                    n_state = S_NYB;
                end
            end
            S_NYB: begin
                o_cmd.nyb_step = 1'b1;
                if (i_stat.nyb_is_run) begin
                    n_state = S_RUN;
                end else if (!r_sel) begin
                    n_sel = 1'b1;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_RUN: begin
                if (i_stat.run_zero || i_stat.finished) begin
                    o_cmd.run_end = 1'b1;
                    if (!r_sel && !i_stat.finished) begin
                        n_sel   = 1'b1;
                        n_state = S_NYB;
                    end else begin
                        n_state = S_LAST;
                    end
                end else if (i_stat.col_ge_w) begin
                    n_ret   = S_RUN;
                    n_state = S_FR1;
                end else begin
                    o_cmd.run_step = 1'b1;
                    if (i_stat.take_fills) begin
                        n_ret   = S_RUN;
                        n_state = S_FR1;
                    end
                end
            end
            S_FR1: begin
                if (!i_stat.rc_lt_h) begin
                    n_state = S_FRR;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_row = 1'b1;
                    n_state = S_FRR;
                end
            end
            S_FRR: begin
                if (i_stat.rep_nz && i_stat.rc_lt_h) begin
                    if (i_stat.out_free) begin
                        o_cmd.emit_row = 1'b1;
                        o_cmd.dec_rep  = 1'b1;
                    end
                end else begin
                    o_cmd.row_final = 1'b1;
                    n_state = r_ret;
                end
            end
            S_RAW: begin
                if (i_stat.finished || i_stat.bits_zero) begin
                    n_state = S_LAST;
                end else if (i_stat.col_ge_w) begin
                    n_ret   = S_RAW;
                    n_state = S_FR1;
                end else begin
                    o_cmd.raw_step = 1'b1;
                    if (i_stat.raw_fills) begin
                        n_ret   = S_RAW;
                        n_state = S_FR1;
                    end
                end
            end
            S_LAST: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr_num = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_stat.finished) begin
                    o_cmd.clr_seen = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.fill = i_stat.raw;
                    n_ret   = S_FILL;
                    n_state = S_FR1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_sel   <= n_sel;
        end
    end

endmodule

/* rtl/pkgrld_dp.sv */
// datapath for the pk glyph decoder: registers, number decoder, row store, output stage
// depends on pkgrld_pkg

module pkgrld_dp #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COUNT_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pkgrld_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pkgrld_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic [7:0]                           i_data_byte,
    input  logic                                 i_last_byte,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [pkgrld_pkg::ROW_BITS-1:0]      o_row_bits,
    output logic [5:0]                           o_row_number,
    output logic                                 o_glyph_done,
    output logic                                 o_short_packet,
    input  pkgrld_pkg::t_cmd                     i_cmd,
    output pkgrld_pkg::t_stat                    o_stat
);
    import pkgrld_pkg::*;

    localparam int CB = COUNT_BITS;
    localparam logic [CB-1:0]  CMAX  = {CB{1'b1}};
    localparam logic [CB:0]    CMAXW = {1'b0, {CB{1'b1}}};
    localparam logic [COL_W-1:0] MAXW = COL_W'(MAX_WIDTH);
    localparam logic [COL_W-1:0] MAXH = COL_W'(MAX_HEIGHT);
    localparam logic [ROW_BITS-1:0] ONES = {ROW_BITS{1'b1}};
    localparam logic [ROW_BITS-1:0] MSB  = {1'b1, {(ROW_BITS-1){1'b0}}};

    logic [3:0]        r_dyn_f;
    logic              r_first_black;
    logic [6:0]        r_width, r_height;
    logic [9:0]        r_pkt_bytes;

    logic [7:0]        r_byte;
    logic              r_last;
    logic [ROW_BITS-1:0] r_store, n_store;
    logic [COL_W-1:0]  r_col, n_col;
    logic [COL_W-1:0]  r_rc, n_rc;
    logic [CB-1:0]     r_run, n_run;
    logic              r_color, n_color;
    logic [CB-1:0]     r_rep, n_rep;
    logic [2:0]        r_phase, n_phase;
    logic [3:0]        r_zeros, n_zeros;
    logic [CB-1:0]     r_acc, n_acc;
    logic [9:0]        r_seen, n_seen;
    logic              r_fin, n_fin;
    logic [3:0]        r_bits, n_bits;

    logic              r_ov, n_ov;
    logic [ROW_BITS-1:0] r_obits, n_obits;
    logic [5:0]        r_onum, n_onum;
    logic              r_odone, n_odone;
    logic              r_oshort, n_oshort;

    logic [COL_W-1:0]  eff_w, eff_h, room, take;
    logic [COL_W:0]    col_take, col_one;
    logic              raw;
    logic [12:0]       area;
    logic [9:0]        need_bytes;
    logic [3:0]        d, v;
    logic [7:0]        d15;
    logic [8:0]        two_val;
    logic [CB+3:0]     dig_full;
    logic [CB-1:0]     dig_acc;
    logic [3:0]        dig_zeros;
    logic [CB:0]       dig_t;
    logic              nd_done, nd_kind;
    logic [CB:0]       nd_val;
    logic [CB-1:0]     nd_sat;
    logic [2:0]        nd_phase;
    logic [3:0]        nd_zeros;
    logic [CB-1:0]     nd_acc;
    logic              nd_rep1;
    logic [ROW_BITS-1:0] span;
    logic [2:0]        bit_idx;
    logic              out_free;

    assign o_cfg_ready = 1'b1;

    assign eff_w = (r_width == '0) ? COL_W'(1) : ((r_width > MAXW) ? MAXW : r_width);
    assign eff_h = (r_height == '0) ? COL_W'(1) : ((r_height > MAXH) ? MAXH : r_height);
    assign raw   = (r_dyn_f >= DYN_F_RAW);
    assign area  = 13'(eff_w) * 13'(eff_h);
    assign need_bytes = 10'((area + 13'd7) >> 3);

    assign room     = eff_w - r_col;
    assign take     = ({{(CB > COL_W ? CB-COL_W : 0){1'b0}}, room} > r_run) ? r_run[COL_W-1:0] : room;
    assign col_take = {1'b0, r_col} + {1'b0, take};
    assign col_one  = {1'b0, r_col} + (COL_W+1)'(1);
    assign span     = (ONES >> r_col) & ~(ONES >> col_take);
    assign bit_idx  = 3'(r_bits - 4'd1);
    assign out_free = !r_ov || i_out_ready;

    // packed number decoder, one nybble
    always_comb begin
        d  = (r_dyn_f > DYN_F_MAX) ? DYN_F_MAX : r_dyn_f;
        v  = i_cmd.nyb_sel ? r_byte[3:0] : r_byte[7:4];
        d15 = 8'(d) * 8'd15;
        two_val = {1'b0, 4'(r_acc[3:0] - d - 4'd1), v} + 9'(d) + 9'd1;
        dig_full = {r_acc, 4'b0} + (CB+4)'(v);
        dig_acc  = (dig_full > (CB+4)'(CMAX)) ? CMAX : dig_full[CB-1:0];
        dig_zeros = (r_zeros != 4'd0) ? r_zeros - 4'd1 : 4'd0;
        dig_t    = {1'b0, dig_acc} + (CB+1)'(193);
        nd_done  = 1'b0;
        nd_kind  = r_phase[0];
        nd_val   = '0;
        nd_phase = r_phase;
        nd_zeros = r_zeros;
        nd_acc   = r_acc;
        nd_rep1  = 1'b0;
        if (r_phase == PH_IDLE || r_phase == PH_REP_FIRST) begin
            if (r_phase == PH_IDLE && v == NYB_REPEAT) begin
                nd_phase = PH_REP_FIRST;
            end else if (r_phase == PH_IDLE && v == NYB_REP1) begin
                nd_rep1 = 1'b1;
            end else if (r_phase == PH_REP_FIRST && v >= NYB_REPEAT) begin
                nd_done = 1'b1;
                nd_kind = 1'b1;
            end else if (v == 4'd0) begin
                nd_zeros = 4'd1;
                nd_phase = PH_ZEROS | {2'b0, r_phase[0]};
            end else if (v <= d) begin
                nd_done = 1'b1;
                nd_val  = (CB+1)'(v);
            end else begin
                nd_acc   = CB'(v);
                nd_phase = PH_TWO | {2'b0, r_phase[0]};
            end
        end else if ((r_phase & 3'd6) == PH_TWO) begin
            nd_done = 1'b1;
            nd_val  = (CB+1)'(two_val);
        end else if ((r_phase & 3'd6) == PH_ZEROS) begin
            if (v == 4'd0) begin
                if (r_zeros < 4'd15) nd_zeros = r_zeros + 4'd1;
            end else begin
                nd_acc   = CB'(v);
                nd_phase = PH_DIGITS | {2'b0, r_phase[0]};
            end
        end else begin
            nd_acc   = dig_acc;
            nd_zeros = dig_zeros;
            if (dig_zeros == 4'd0) begin
                nd_done = 1'b1;
                nd_val  = (dig_t >= (CB+1)'(d15)) ? dig_t - (CB+1)'(d15) : '0;
            end
        end
        nd_sat = (nd_val > CMAXW) ? CMAX : nd_val[CB-1:0];
    end

    always_comb begin
        o_stat.seen_zero  = (r_seen == '0);
        o_stat.raw        = raw;
        o_stat.short_pkt  = (r_pkt_bytes < need_bytes);
        o_stat.finished   = r_fin;
        o_stat.nyb_is_run = nd_done && !nd_kind;
        o_stat.run_zero   = (r_run == '0);
        o_stat.col_ge_w   = (r_col >= eff_w);
        o_stat.take_fills = (col_take >= {1'b0, eff_w});
        o_stat.raw_fills  = (col_one >= {1'b0, eff_w});
        o_stat.rc_lt_h    = (r_rc < eff_h);
        o_stat.rep_nz     = (r_rep != '0);
        o_stat.bits_zero  = (r_bits == 4'd0);
        o_stat.last       = r_last;
        o_stat.out_free   = out_free;
    end

    always_comb begin
        n_store = r_store;
        n_col   = r_col;
        n_rc    = r_rc;
        n_run   = r_run;
        n_color = r_color;
        n_rep   = r_rep;
        n_phase = r_phase;
        n_zeros = r_zeros;
        n_acc   = r_acc;
        n_seen  = r_seen;
        n_fin   = r_fin;
        n_bits  = r_bits;
        n_ov    = r_ov && !i_out_ready;
        n_obits = r_obits;
        n_onum  = r_onum;
        n_odone = r_odone;
        n_oshort = r_oshort;

        if (i_cmd.start) begin
            n_rc    = '0;
            n_run   = '0;
            n_rep   = '0;
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_zeros = '0;
            n_fin   = 1'b0;
            n_color = !r_first_black;
            n_store = raw ? '0 : ONES;
            n_col   = '0;
        end
        if (i_cmd.inc_seen && r_seen < SEEN_MAX) n_seen = r_seen + 10'd1;
        if (i_cmd.clr_seen) n_seen = '0;
        if (i_cmd.emit_err) begin
            n_ov     = 1'b1;
            n_obits  = '0;
            n_onum   = '0;
            n_odone  = 1'b1;
            n_oshort = 1'b1;
            n_fin    = 1'b1;
        end
        if (i_cmd.nyb_step) begin
            n_phase = nd_phase;
            n_zeros = nd_zeros;
            n_acc   = nd_acc;
            if (nd_rep1) n_rep = CB'(1);
            if (nd_done) begin
                n_phase = PH_IDLE;
                n_acc   = '0;
                n_zeros = '0;
                if (nd_kind) n_rep = nd_sat;
                else n_run = nd_sat;
            end
        end
        if (i_cmd.run_step) begin
            if (!r_color) n_store = r_store & ~span;
            n_col = col_take[COL_W-1:0];
            n_run = r_run - CB'(take);
        end
        if (i_cmd.run_end) begin
            n_run   = '0;
            n_color = !r_color;
        end
        if (i_cmd.emit_row) begin
            n_ov     = 1'b1;
            n_obits  = r_store;
            n_onum   = r_rc[5:0];
            n_odone  = ((r_rc + COL_W'(1)) >= eff_h);
            n_oshort = 1'b0;
            n_rc     = r_rc + COL_W'(1);
            if (i_cmd.dec_rep) n_rep = r_rep - CB'(1);
        end
        if (i_cmd.row_final) begin
            n_rep = '0;
            if (r_rc >= eff_h) begin
                n_fin = 1'b1;
                n_run = '0;
            end
            n_store = raw ? '0 : ONES;
            n_col   = '0;
        end
        if (i_cmd.raw_begin) begin
            n_rep  = '0;
            n_bits = 4'd8;
        end
        if (i_cmd.raw_step) begin
            if (!r_byte[bit_idx]) n_store = r_store | (MSB >> r_col);
            n_col  = col_one[COL_W-1:0];
            n_bits = r_bits - 4'd1;
        end
        if (i_cmd.fill) begin
            n_rep = '0;
            if (r_col < eff_w) n_store = r_store | ((ONES >> r_col) & ~(ONES >> eff_w));
        end
        if (i_cmd.clr_num) begin
            n_phase = PH_IDLE;
            n_acc   = '0;
            n_zeros = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dyn_f       <= '0;
            r_first_black <= 1'b0;
            r_width       <= 7'd1;
            r_height      <= 7'd1;
            r_pkt_bytes   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DYN_F:       r_dyn_f       <= i_cfg_data[3:0];
                REG_FIRST_BLACK: r_first_black <= i_cfg_data[0];
                REG_WIDTH:       r_width       <= i_cfg_data[6:0];
                REG_HEIGHT:      r_height      <= i_cfg_data[6:0];
                REG_PKT_BYTES:   r_pkt_bytes   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= ONES;
            r_col   <= '0;
            r_rc    <= '0;
            r_run   <= '0;
            r_color <= 1'b1;
            r_rep   <= '0;
            r_phase <= PH_IDLE;
            r_zeros <= '0;
            r_acc   <= '0;
            r_seen  <= '0;
            r_fin   <= 1'b0;
            r_bits  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_store <= n_store;
            r_col   <= n_col;
            r_rc    <= n_rc;
            r_run   <= n_run;
            r_color <= n_color;
            r_rep   <= n_rep;
            r_phase <= n_phase;
            r_zeros <= n_zeros;
            r_acc   <= n_acc;
            r_seen  <= n_seen;
            r_fin   <= n_fin;
            r_bits  <= n_bits;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_data_byte;
            r_last <= i_last_byte;
        end
        r_obits  <= n_obits;
        r_onum   <= n_onum;
        r_odone  <= n_odone;
        r_oshort <= n_oshort;
    end

    assign o_out_valid    = r_ov;
    assign o_row_bits     = r_obits;
    assign o_row_number   = r_onum;
    assign o_glyph_done   = r_odone;
    assign o_short_packet = r_oshort;

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_W'(ROW_BITS))
        else $error("column position past row end");

    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_oshort) |-> (r_odone && r_onum == 6'd0 && r_obits == '0))
        else $error("error item malformed");

    a_no_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit_row || i_cmd.emit_err) |-> out_free)
        else $error("item written into a full output stage");

    a_rows_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_row |-> (r_rc < eff_h))
        else $error("row past glyph height");

endmodule

/* tb/tb_pk_glyph_run_length_decoder.sv */
// testbench for the pk glyph run length decoder: directed and random glyph packets
// depends on pkgrld_pkg and pk_glyph_run_length_decoder; rows checked against a local model
`timescale 1ns / 1ps

module tb_pk_glyph_run_length_decoder;
    import pkgrld_pkg::*;

    localparam int CNT_MAX = (1 << 24) - 1;
    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [9:0]  i_cfg_data = '0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_last_byte = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [63:0] o_row_bits;
    logic [5:0]  o_row_number;
    logic        o_glyph_done;
    logic        o_short_packet;

    pk_glyph_run_length_decoder uut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [63:0] bits;
        logic [5:0]  num;
        logic        done;
        logic        shortp;
    } t_row;

    t_row rows_due[$];
    int errors = 0;
    int rows_seen = 0;
    int glyphs_sent = 0;
    int bytes_sent = 0;
    longint cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;

    // shadow registers and decoder state
    int m_dyn, m_black, m_w, m_h, m_pkt;
    logic [63:0] s_row;
    int s_col, s_rc, s_color, s_phase, s_zeros, s_seen, s_fin;
    longint s_acc, s_rep;

    function automatic int eff_w();
        return m_w < 1 ? 1 : (m_w > 64 ? 64 : m_w);
    endfunction
    function automatic int eff_h();
        return m_h < 1 ? 1 : (m_h > 64 ? 64 : m_h);
    endfunction
    function automatic bit is_raw();
        return m_dyn >= 14;
    endfunction

    function automatic logic [63:0] span(int col, int len);
        logic [63:0] m;
        if (len <= 0 || col >= 64) return 64'd0;
        if (col + len > 64) len = 64 - col;
        m = (len >= 64) ? '1 : ((64'd1 << len) - 1);
        return m << (64 - col - len);
    endfunction

    function automatic void push_row(logic [63:0] b, int n, bit d, bit s);
        t_row r;
        r.bits = b; r.num = n[5:0]; r.done = d; r.shortp = s;
        rows_due.push_back(r);
    endfunction

    function automatic void clear_row();
        s_row = is_raw() ? 64'd0 : '1;
        s_col = 0;
    endfunction

    function automatic void close_row();
        int h;
        h = eff_h();
        if (s_rc < h) begin
            push_row(s_row, s_rc, s_rc + 1 >= h, 1'b0); s_rc++;
        end
        while (s_rep > 0 && s_rc < h) begin
            push_row(s_row, s_rc, s_rc + 1 >= h, 1'b0); s_rc++; s_rep--;
        end
        s_rep = 0;
        if (s_rc >= h) s_fin = 1;
        clear_row();
    endfunction

    function automatic void paint_run(longint len);
        int w, room, take;
        w = eff_w();
        while (len > 0 && !s_fin) begin
            if (s_col >= w) begin
                close_row();
                continue;
            end
            room = w - s_col;
            take = (len < room) ? int'(len) : room;
            if (!s_color) s_row &= ~span(s_col, take);
            s_col += take;
            len -= take;
            if (s_col >= w) close_row();
        end
        s_color ^= 1;
    endfunction

    function automatic void number_end(int kind, longint v);
        s_phase = PH_IDLE; s_acc = 0; s_zeros = 0;
        if (v > CNT_MAX) v = CNT_MAX;
        if (kind) s_rep = v;
        else paint_run(v);
    endfunction

    function automatic void take_nybble(int v);
        int d, kind, base;
        longint a;
        d = m_dyn > 13 ? 13 : m_dyn;
        kind = s_phase & 1;
        base = s_phase & 6;
        if (s_phase == PH_IDLE || s_phase == PH_REP_FIRST) begin
            if (s_phase == PH_IDLE) begin
                if (v == NYB_REPEAT) begin
                    s_phase = PH_REP_FIRST;
                    return;
                end
                if (v == NYB_REP1) begin
                    s_rep = 1;
                    return;
                end
                kind = 0;
            end else begin
                kind = 1;
                if (v >= 14) begin
                    number_end(1, 0);
                    return;
                end
            end
            if (v == 0) begin
                s_zeros = 1; s_phase = PH_ZEROS | kind;
            end else if (v <= d) begin
                number_end(kind, v);
            end else begin
                s_acc = v; s_phase = PH_TWO | kind;
            end
            return;
        end
        if (base == PH_TWO) begin
            number_end(kind, (s_acc - d - 1) * 16 + v + d + 1);
        end else if (base == PH_ZEROS) begin
            if (v == 0) begin
                if (s_zeros < 15) s_zeros++;
            end else begin
                s_acc = v; s_phase = PH_DIGITS | kind;
            end
        end else begin
            a = s_acc * 16 + v;
            s_acc = a > CNT_MAX ? CNT_MAX : a;
            if (s_zeros > 0) s_zeros--;
            if (s_zeros == 0) begin
                a = s_acc + 193;
                a = (a >= 15 * d) ? a - 15 * d : 0;
                number_end(kind, a);
            end
        end
    endfunction

    function automatic void take_raw(logic [7:0] b);
        int w;
        w = eff_w();
        s_rep = 0;
        for (int k = 7; k >= 0 && !s_fin; k--) begin
            if (s_col >= w) begin
                close_row();
                if (s_fin) break;
            end
            if (!b[k]) s_row |= span(s_col, 1);
            s_col++;
            if (s_col >= w) close_row();
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, bit last);
        if (s_seen == 0) begin
            s_rc = 0; s_rep = 0; s_phase = PH_IDLE; s_acc = 0; s_zeros = 0; s_fin = 0;
            s_color = m_black ? 0 : 1;
            clear_row();
            if (is_raw() && m_pkt < (eff_w() * eff_h() + 7) / 8) begin
                push_row(64'd0, 0, 1'b1, 1'b1);
                s_fin = 1;
            end
        end
        if (s_seen < 1023) s_seen++;
        if (!s_fin) begin
            if (is_raw()) take_raw(b);
            else begin
                take_nybble(int'(b[7:4]));
                if (!s_fin) take_nybble(int'(b[3:0]));
            end
        end
        if (last) begin
            s_phase = PH_IDLE; s_acc = 0; s_zeros = 0;
            while (!s_fin) begin
                if (is_raw()) begin
                    s_rep = 0;
                    if (s_col < eff_w()) s_row |= span(s_col, eff_w() - s_col);
                end
                close_row();
            end
            s_seen = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n)
            i_out_ready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                $display("%0t unexpected row: bits %h num %0d", $time, o_row_bits, o_row_number);
                errors++;
            end else begin
                e = rows_due.pop_front();
                if (e.bits !== o_row_bits || e.num !== o_row_number ||
                    e.done !== o_glyph_done || e.shortp !== o_short_packet) begin
                    $display("%0t mismatch: expected %h/%0d/%0b/%0b actual %h/%0d/%0b/%0b",
                             $time, e.bits, e.num, e.done, e.shortp,
                             o_row_bits, o_row_number, o_glyph_done, o_short_packet);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1; i_cfg_index <= idx; i_cfg_data <= val[9:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            REG_DYN_F:       m_dyn = val & 15;
            REG_FIRST_BLACK: m_black = val & 1;
            REG_WIDTH:       m_w = val & 127;
            REG_HEIGHT:      m_h = val & 127;
            default:         m_pkt = val & 1023;
        endcase
    endtask

    task automatic drain();
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic setup(int dyn, int blk, int w, int h, int pkt);
        drain();
        write_reg(REG_DYN_F, dyn);
        write_reg(REG_FIRST_BLACK, blk);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_PKT_BYTES, pkt);
    endtask

    task automatic send_byte(logic [7:0] b, bit last);
        @(posedge i_clk);
        while ($urandom_range(99) < send_idle) @(posedge i_clk);
        i_in_valid <= 1; i_data_byte <= b; i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(b, last);
        bytes_sent++;
        if (last) glyphs_sent++;
        i_in_valid <= 0;
    endtask

    task automatic test_directed();
        setup(DYN_F_MAX, 0, 64, 64, 0);
        send_byte(8'h00, 0);
        send_byte(8'hff, 0);
        send_byte(8'h3e, 0);
        send_byte(8'h27, 1);
        setup(0, 1, 1, 1, 0);
        send_byte(8'h11, 1);
        setup(7, 1, 10, 8, 0);
        send_byte(8'h9a, 0);
        send_byte(8'hef, 0);
        send_byte(8'h00, 0);
        send_byte(8'h0f, 0);
        send_byte(8'hf5, 0);
        send_byte(8'he0, 0);
        send_byte(8'h31, 1);
        setup(DYN_F_RAW, 0, 9, 3, 4);
        send_byte(8'h55, 0);
        send_byte(8'hff, 0);
        send_byte(8'h00, 1);
        setup(DYN_F_RAW, 1, 64, 64, 10);
        send_byte(8'ha5, 1);
        setup(15, 0, 8, 8, 1023);
        send_byte(8'hc3, 1);
        setup(4, 0, 0, 100, 0);
        send_byte(8'hff, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'h00, 0);
        send_byte(8'h01, 1);
    endtask

    task automatic test_random(int count);
        int dyn, w, h, n, need;
        while (count > 0) begin
            dyn = $urandom_range(15);
            w = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 16);
            h = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(1, 10);
            need = ((w < 1 ? 1 : (w > 64 ? 64 : w)) * (h < 1 ? 1 : (h > 64 ? 64 : h)) + 7) / 8;
            setup(dyn, $urandom_range(1), w, h,
                  ($urandom_range(4) == 0) ? $urandom_range(1023) : need + $urandom_range(3));
            n = (dyn >= 14) ? need + $urandom_range(2) : $urandom_range(1, 12);
            if ($urandom_range(5) == 0) n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
                send_byte(8'($urandom_range(255)), k == n - 1);
                count--;
            end
        end
    endtask

    task automatic test_pause();
        setup(2, 0, 12, 6, 0);
        send_byte(8'h35, 0);
        while (rows_due.size() != 0) @(posedge i_clk);
        send_byte(8'h7e, 0);
        send_byte(8'h24, 1);
    endtask

    initial begin
        m_dyn = 0; m_black = 0; m_w = 1; m_h = 1; m_pkt = 0;
        s_row = '1; s_col = 0; s_rc = 0; s_color = 1; s_phase = PH_IDLE;
        s_zeros = 0; s_seen = 0; s_fin = 0; s_acc = 0; s_rep = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        test_directed();
        send_idle = 0;  recv_stall = 0;  test_random(115);
        send_idle = 66; recv_stall = 0;  test_random(115);
        send_idle = 0;  recv_stall = 66; test_random(115);
        send_idle = 13; recv_stall = 13; test_random(115);
        test_pause();
        drain();
        $display("sent %0d bytes in %0d glyphs, checked %0d rows", bytes_sent, glyphs_sent,
                 rows_seen);
        $display("packed and raw modes, repeats, short packets and size clamps covered");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/pkgrld_pkg.sv
rtl/pkgrld_ctrl.sv
rtl/pkgrld_dp.sv
rtl/pk_glyph_run_length_decoder.sv
tb/tb_pk_glyph_run_length_decoder.sv
